// ----- src/fpls_pkg.sv -----
// Package with the shared types, codes and constants of the flash parameter log store.
package fpls_pkg;

  localparam int SECTION_WORDS_DEF = 512;
  localparam int MAX_SLOTS_DEF     = 16;

  localparam logic [31:0] MAGIC_WORD   = 32'h55AAF50A;
  localparam logic [31:0] CLEARED_WORD = 32'h00000000;
  localparam logic [31:0] ERASED_WORD  = 32'hFFFFFFFF;

  localparam logic [2:0] REQ_MOUNT   = 3'd0;
  localparam logic [2:0] REQ_DEFINE  = 3'd1;
  localparam logic [2:0] REQ_GET     = 3'd2;
  localparam logic [2:0] REQ_SET     = 3'd3;
  localparam logic [2:0] REQ_FACTORY = 3'd4;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_RESERVED  = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] key;
    logic [15:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_value;
    logic [3:0]  slot_index;
    logic        change_event;
    logic        compacted;
    logic [4:0]  param_count;
  } out_rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR_WR,
    OP_RD_LOW_HDR,
    OP_RD_HIGH_HDR,
    OP_MOUNT_LOW,
    OP_MOUNT_HIGH,
    OP_FMT_LOW_INIT,
    OP_FMT_NEW_INIT,
    OP_FMT_WR,
    OP_RESERVED,
    OP_NOT_FOUND,
    OP_FULL,
    OP_FS_INIT,
    OP_FS_RD,
    OP_FS_HIT,
    OP_IDX_INC,
    OP_SC_INIT,
    OP_SC_RD,
    OP_SC_HIT,
    OP_SC_NEXT,
    OP_APPEND_FREE,
    OP_BIND,
    OP_TAKE_VAL,
    OP_AP_CLR,
    OP_AP_PUT,
    OP_SET_FIN,
    OP_CP_INIT,
    OP_CP_STEP,
    OP_SWAP_FIN,
    OP_SWAP_PUT,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       reserved;
    logic       magic;
    logic       key_hit;
    logic       erased;
    logic       scan_last;
    logic       fmt_last;
    logic       clr_last;
    logic       idx_end;
    logic       full;
    logic       free_found;
  } dp_stat_t;

endpackage

// ----- src/fpls_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fpls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fpls_ctrl.sv -----
// Controller state machine that sequences the datapath through each request.
module fpls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fpls_pkg::dp_stat_t st,
  output fpls_pkg::dp_cmd_t  cmd
);
  import fpls_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_M_CK0, S_M_CK1, S_FMT, S_FMT_END,
    S_FS_RD, S_FS_CK, S_SC_RD, S_SC_CK, S_DF_DEC, S_BIND, S_VAL,
    S_AP_INIT, S_AP_RD, S_AP_CK, S_SET_FIN, S_SW_INIT, S_CP_INIT,
    S_CP_RD, S_CP_CK, S_SW_FIN, S_SW_PUT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   fmt_copy_r, fmt_copy_nxt;
  logic   swap_set_r, swap_set_nxt;
  dp_op_t op;

  always_comb begin
    state_nxt    = state_r;
    fmt_copy_nxt = fmt_copy_r;
    swap_set_nxt = swap_set_r;
    op           = OP_NONE;
    case (state_r)
      S_CLR: begin
        op = OP_CLEAR_WR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (st.req_type == REQ_MOUNT) begin
          op        = OP_RD_LOW_HDR;
          state_nxt = S_M_CK0;
        end else if (st.req_type == REQ_FACTORY) begin
          op           = OP_FMT_LOW_INIT;
          fmt_copy_nxt = 1'b0;
          state_nxt    = S_FMT;
        end else if (st.req_type == REQ_DEFINE || st.req_type == REQ_GET ||
                     st.req_type == REQ_SET) begin
          if (st.reserved) begin
            op        = OP_RESERVED;
            state_nxt = S_DONE;
          end else begin
            op        = OP_FS_INIT;
            state_nxt = S_FS_RD;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_M_CK0: begin
        if (st.magic) begin
          op        = OP_MOUNT_LOW;
          state_nxt = S_DONE;
        end else begin
          op        = OP_RD_HIGH_HDR;
          state_nxt = S_M_CK1;
        end
      end
      S_M_CK1: begin
        if (st.magic) begin
          op        = OP_MOUNT_HIGH;
          state_nxt = S_DONE;
        end else begin
          op           = OP_FMT_LOW_INIT;
          fmt_copy_nxt = 1'b0;
          state_nxt    = S_FMT;
        end
      end
      S_FMT: begin
        op = OP_FMT_WR;
        if (st.fmt_last) state_nxt = fmt_copy_r ? S_CP_INIT : S_FMT_END;
      end
      S_FMT_END: begin
        op        = OP_MOUNT_LOW;
        state_nxt = S_DONE;
      end
      S_FS_RD: begin
        if (st.idx_end) begin
          if (st.req_type == REQ_DEFINE) begin
            if (st.full) begin
              op        = OP_FULL;
              state_nxt = S_DONE;
            end else begin
              op        = OP_SC_INIT;
              state_nxt = S_SC_RD;
            end
          end else begin
            op        = OP_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end else begin
          op        = OP_FS_RD;
          state_nxt = S_FS_CK;
        end
      end
      S_FS_CK: begin
        if (st.key_hit) begin
          op        = OP_FS_HIT;
          state_nxt = (st.req_type == REQ_SET) ? S_AP_INIT : S_DONE;
        end else begin
          op        = OP_IDX_INC;
          state_nxt = S_FS_RD;
        end
      end
      S_SC_RD: begin
        op        = OP_SC_RD;
        state_nxt = S_SC_CK;
      end
      S_SC_CK: begin
        if (st.key_hit) begin
          op        = OP_SC_HIT;
          state_nxt = S_BIND;
        end else begin
          op        = OP_SC_NEXT;
          state_nxt = st.scan_last ? S_DF_DEC : S_SC_RD;
        end
      end
      S_DF_DEC: begin
        if (st.free_found) begin
          op        = OP_APPEND_FREE;
          state_nxt = S_BIND;
        end else begin
          swap_set_nxt = 1'b0;
          state_nxt    = S_SW_INIT;
        end
      end
      S_BIND: begin
        op        = OP_BIND;
        state_nxt = S_VAL;
      end
      S_VAL: begin
        op        = OP_TAKE_VAL;
        state_nxt = S_DONE;
      end
      S_AP_INIT: begin
        op        = OP_SC_INIT;
        state_nxt = S_AP_RD;
      end
      S_AP_RD: begin
        op        = OP_SC_RD;
        state_nxt = S_AP_CK;
      end
      S_AP_CK: begin
        if (!st.key_hit && st.erased) begin
          op        = OP_AP_PUT;
          state_nxt = S_SET_FIN;
        end else begin
          op = st.key_hit ? OP_AP_CLR : OP_SC_NEXT;
          if (st.scan_last) begin
            swap_set_nxt = 1'b1;
            state_nxt    = S_SW_INIT;
          end else begin
            state_nxt = S_AP_RD;
          end
        end
      end
      S_SET_FIN: begin
        op        = OP_SET_FIN;
        state_nxt = S_DONE;
      end
      S_SW_INIT: begin
        op           = OP_FMT_NEW_INIT;
        fmt_copy_nxt = 1'b1;
        state_nxt    = S_FMT;
      end
      S_CP_INIT: begin
        op        = OP_CP_INIT;
        state_nxt = S_CP_RD;
      end
      S_CP_RD: begin
        if (st.idx_end) begin
          state_nxt = S_SW_FIN;
        end else begin
          op        = OP_FS_RD;
          state_nxt = S_CP_CK;
        end
      end
      S_CP_CK: begin
        op        = OP_CP_STEP;
        state_nxt = S_CP_RD;
      end
      S_SW_FIN: begin
        op        = OP_SWAP_FIN;
        state_nxt = S_SW_PUT;
      end
      S_SW_PUT: begin
        op        = OP_SWAP_PUT;
        state_nxt = swap_set_r ? S_SET_FIN : S_BIND;
      end
      S_DONE: begin
        op        = OP_DONE;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      busy_r     <= 1'b1;
      fmt_copy_r <= 1'b0;
      swap_set_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= busy_nxt;
      fmt_copy_r <= fmt_copy_nxt;
      swap_set_r <= swap_set_nxt;
    end
  end

  assign busy   = busy_r;
  assign cmd.op = op;

endmodule

// ----- src/fpls_datapath.sv -----
// Datapath with the flash array, slot pointers, scan cursors and result register.
module fpls_datapath #(
  parameter int SECTION_WORDS = fpls_pkg::SECTION_WORDS_DEF,
  parameter int MAX_SLOTS     = fpls_pkg::MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpls_pkg::dp_cmd_t  cmd,
  output fpls_pkg::dp_stat_t st,
  input  fpls_pkg::in_req_t  in_req,
  output logic               out_valid,
  output fpls_pkg::out_rsp_t out_rsp
);
  import fpls_pkg::*;

  localparam int Depth = 2 * SECTION_WORDS;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam logic [AW-1:0] SecBase = AW'(SECTION_WORDS);
  localparam logic [AW-1:0] SecLast = AW'(SECTION_WORDS - 1);
  localparam logic [AW-1:0] MemLast = AW'(Depth - 1);
  localparam logic [AW:0]   SecSize = (AW + 1)'(SECTION_WORDS);
  localparam logic [CW-1:0] SlotMax = CW'(MAX_SLOTS);

  in_req_t       req_r, req_nxt;
  logic          active_r, active_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ptr_r [MAX_SLOTS];
  logic [AW-1:0] ptr_nxt [MAX_SLOTS];
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] fmt_base_r, fmt_base_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW:0]   fill_r, fill_nxt;
  logic [AW-1:0] hit_addr_r, hit_addr_nxt;
  logic          free_found_r, free_found_nxt;
  logic [AW-1:0] free_addr_r, free_addr_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [15:0]   rval_r, rval_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          change_r, change_nxt;
  logic          swap_r, swap_nxt;
  out_rsp_t      out_rsp_r, out_rsp_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [AW-1:0] act_base, new_base, act_last;
  logic [AW:0]   act_end, new_end;
  logic [31:0]   rec;
  logic [IW-1:0] idx_sel;
  logic [IW+3:0] slot_ext;
  logic [CW+4:0] cnt_ext;

  assign act_base = active_r ? SecBase : '0;
  assign new_base = active_r ? '0 : SecBase;
  assign act_last = act_base + SecLast;
  assign act_end  = {1'b0, act_base} + SecSize;
  assign new_end  = {1'b0, new_base} + SecSize;
  assign rec      = {req_r.value, req_r.key};
  assign idx_sel  = idx_r[IW-1:0];
  assign slot_ext = {4'b0, slot_r};
  assign cnt_ext  = {5'b0, cnt_r};

  fpls_ram #(
    .WIDTH(32),
    .DEPTH(Depth)
  ) u_flash (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    st.req_type   = req_r.req_type;
    st.reserved   = (req_r.key == 16'h0000) || (req_r.key == 16'hFFFF);
    st.magic      = (ram_rdata == MAGIC_WORD);
    st.key_hit    = (ram_rdata[15:0] == req_r.key);
    st.erased     = (ram_rdata == ERASED_WORD);
    st.scan_last  = (addr_r == act_last);
    st.fmt_last   = (addr_r == fmt_base_r + SecLast);
    st.clr_last   = (addr_r == MemLast);
    st.idx_end    = (idx_r == cnt_r);
    st.full       = (cnt_r == SlotMax);
    st.free_found = free_found_r;
  end

  always_comb begin
    req_nxt        = req_r;
    active_nxt     = active_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    addr_nxt       = addr_r;
    fmt_base_nxt   = fmt_base_r;
    idx_nxt        = idx_r;
    fill_nxt       = fill_r;
    hit_addr_nxt   = hit_addr_r;
    free_found_nxt = free_found_r;
    free_addr_nxt  = free_addr_r;
    slot_nxt       = slot_r;
    rval_nxt       = rval_r;
    status_nxt     = status_r;
    change_nxt     = change_r;
    swap_nxt       = swap_r;
    out_rsp_nxt    = out_rsp_r;
    out_valid_nxt  = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = ERASED_WORD;
    ram_raddr      = addr_r;
    case (cmd.op)
      OP_LOAD: begin
        req_nxt    = in_req;
        status_nxt = STS_OK;
        rval_nxt   = '0;
        slot_nxt   = '0;
        change_nxt = 1'b0;
        swap_nxt   = 1'b0;
      end
      OP_CLEAR_WR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
      end
      OP_RD_LOW_HDR: ram_raddr = '0;
      OP_RD_HIGH_HDR: ram_raddr = SecBase;
      OP_MOUNT_LOW: begin
        active_nxt = 1'b0;
        cnt_nxt    = '0;
      end
      OP_MOUNT_HIGH: begin
        active_nxt = 1'b1;
        cnt_nxt    = '0;
      end
      OP_FMT_LOW_INIT: begin
        addr_nxt     = '0;
        fmt_base_nxt = '0;
      end
      OP_FMT_NEW_INIT: begin
        addr_nxt     = new_base;
        fmt_base_nxt = new_base;
      end
      OP_FMT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (addr_r == fmt_base_r) ? MAGIC_WORD : ERASED_WORD;
        addr_nxt  = addr_r + AW'(1);
      end
      OP_RESERVED: status_nxt = STS_RESERVED;
      OP_NOT_FOUND: status_nxt = STS_NOT_FOUND;
      OP_FULL: status_nxt = STS_FULL;
      OP_FS_INIT: idx_nxt = '0;
      OP_FS_RD: ram_raddr = ptr_r[idx_sel];
      OP_FS_HIT: begin
        slot_nxt = idx_sel;
        rval_nxt = ram_rdata[31:16];
      end
      OP_IDX_INC: idx_nxt = idx_r + CW'(1);
      OP_SC_INIT: begin
        addr_nxt       = act_base + AW'(1);
        free_found_nxt = 1'b0;
      end
      OP_SC_RD: ram_raddr = addr_r;
      OP_SC_HIT: hit_addr_nxt = addr_r;
      OP_SC_NEXT: begin
        if (st.erased && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_addr_nxt  = addr_r;
        end
        addr_nxt = addr_r + AW'(1);
      end
      OP_APPEND_FREE: begin
        ram_we       = 1'b1;
        ram_waddr    = free_addr_r;
        ram_wdata    = rec;
        hit_addr_nxt = free_addr_r;
      end
      OP_BIND: begin
        ptr_nxt[cnt_r[IW-1:0]] = hit_addr_r;
        slot_nxt               = cnt_r[IW-1:0];
        cnt_nxt                = cnt_r + CW'(1);
        ram_raddr              = hit_addr_r;
      end
      OP_TAKE_VAL: rval_nxt = ram_rdata[31:16];
      OP_AP_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = CLEARED_WORD;
        addr_nxt  = addr_r + AW'(1);
      end
      OP_AP_PUT: begin
        ram_we       = 1'b1;
        ram_wdata    = rec;
        hit_addr_nxt = addr_r;
      end
      OP_SET_FIN: begin
        ptr_nxt[slot_r] = hit_addr_r;
        rval_nxt        = req_r.value;
        change_nxt      = 1'b1;
      end
      OP_CP_INIT: begin
        idx_nxt  = '0;
        fill_nxt = {1'b0, new_base} + (AW + 1)'(1);
      end
      OP_CP_STEP: begin
        if (ram_rdata[15:0] != 16'h0000 && fill_r < new_end) begin
          ram_we           = 1'b1;
          ram_waddr        = fill_r[AW-1:0];
          ram_wdata        = ram_rdata;
          ptr_nxt[idx_sel] = fill_r[AW-1:0];
          fill_nxt         = fill_r + (AW + 1)'(1);
        end
        idx_nxt = idx_r + CW'(1);
      end
      OP_SWAP_FIN: begin
        ram_we     = 1'b1;
        ram_waddr  = act_base;
        ram_wdata  = CLEARED_WORD;
        active_nxt = ~active_r;
        swap_nxt   = 1'b1;
      end
      OP_SWAP_PUT: begin
        if (fill_r < act_end) begin
          ram_we       = 1'b1;
          ram_waddr    = fill_r[AW-1:0];
          ram_wdata    = rec;
          hit_addr_nxt = fill_r[AW-1:0];
        end else begin
          hit_addr_nxt = act_last;
        end
      end
      OP_DONE: begin
        out_rsp_nxt.status       = status_r;
        out_rsp_nxt.read_value   = rval_r;
        out_rsp_nxt.slot_index   = slot_ext[3:0];
        out_rsp_nxt.change_event = change_r;
        out_rsp_nxt.compacted    = swap_r;
        out_rsp_nxt.param_count  = cnt_ext[4:0];
        out_valid_nxt            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    ptr_r        <= ptr_nxt;
    fmt_base_r   <= fmt_base_nxt;
    idx_r        <= idx_nxt;
    fill_r       <= fill_nxt;
    hit_addr_r   <= hit_addr_nxt;
    free_found_r <= free_found_nxt;
    free_addr_r  <= free_addr_nxt;
    slot_r       <= slot_nxt;
    rval_r       <= rval_nxt;
    status_r     <= status_nxt;
    change_r     <= change_nxt;
    swap_r       <= swap_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ----- src/flash_parameter_log_store_top.sv -----
// Top level of the flash parameter log store: controller, datapath and flash array.
//
// The store keeps key/value records as an append-only log in two flash sections of
// SECTION_WORDS words each, held in one single-port-read RAM of 2*SECTION_WORDS words.
// After reset, busy stays high while the whole array is erased
// word by word. A request is taken when start is high and busy is low; its response
// appears on out_rsp for exactly one cycle with out_valid, and the receiver must take
// it then. Each flash read is followed by a check state, so the response time is set
// by the scan loops over the slot pointers and the section words, and a request that
// compacts also formats the new section and copies the live records into it.
module flash_parameter_log_store_top #(
  parameter int SECTION_WORDS = fpls_pkg::SECTION_WORDS_DEF,
  parameter int MAX_SLOTS     = fpls_pkg::MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fpls_pkg::in_req_t  in_req,
  output logic               out_valid,
  output fpls_pkg::out_rsp_t out_rsp
);
  import fpls_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  fpls_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  fpls_datapath #(
    .SECTION_WORDS(SECTION_WORDS),
    .MAX_SLOTS    (MAX_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

`ifndef SYNTHESIS
  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("Response strobe while a request is in progress.");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("Response strobe lasted more than one cycle.");
  a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("Accepted request did not raise busy.");
`endif

endmodule
